### rtl/gzhp_pkg.sv
// Shared types and constants for the gzip/zlib header parser.
// No dependencies; used by gzip_zlib_header_parser.
`timescale 1ns / 1ps

package gzhp_pkg;

    // Parse phases, one-hot
    typedef enum logic [9:0] {
        PH_IDLE  = 10'b00_0000_0001,
        PH_DONE  = 10'b00_0000_0010,
        PH_Z0    = 10'b00_0000_0100,
        PH_Z1    = 10'b00_0000_1000,
        PH_GFIX  = 10'b00_0001_0000,
        PH_XLEN  = 10'b00_0010_0000,
        PH_XDATA = 10'b00_0100_0000,
        PH_NAME  = 10'b00_1000_0000,
        PH_COMM  = 10'b01_0000_0000,
        PH_HCRC  = 10'b10_0000_0000
    } phase_t;

    // Result status codes
    localparam logic [2:0] ST_ZLIB_OK  = 3'd0;
    localparam logic [2:0] ST_RAW      = 3'd1;
    localparam logic [2:0] ST_GZIP_OK  = 3'd2;
    localparam logic [2:0] ST_BAD_ZLIB = 3'd3;
    localparam logic [2:0] ST_BAD_GZIP = 3'd4;
    localparam logic [2:0] ST_DICT     = 3'd5;

    // Header constants
    localparam logic [7:0] GZIP_ID1      = 8'd31;
    localparam logic [7:0] GZIP_ID2      = 8'd139;
    localparam logic [3:0] ZLIB_CM_DEFL  = 4'd8;
    localparam int         ZLIB_FDICT    = 5;
    localparam logic [3:0] GZIP_FIX_LEN  = 4'd10;
    localparam logic [3:0] GZIP_FLG_POS  = 4'd3;
    localparam int         FLG_HCRC      = 1;
    localparam int         FLG_EXTRA     = 2;
    localparam int         FLG_NAME      = 3;
    localparam int         FLG_COMMENT   = 4;
    localparam int         OUT_LEN_BITS  = 20;

endpackage

### rtl/gzip_zlib_header_parser.sv
// Gzip / zlib header parser top level: phase machine and result register.
// Depends on gzhp_pkg.
`timescale 1ns / 1ps

// A result is registered: it appears in m_* in the cycle after the word that finishes the header is taken.
// Throughput: one input word per cycle while m_ready is high; the phase machine computes its
// next state combinationally and the result register reloads in the cycle its word is taken. s_ready drops
// whenever a result is held and m_ready is low, even for words that produce no result.
// Reset (aresetn low, synchronous): idle phase, counters and flags zero, stream_format 0,
// no result pending.
module gzip_zlib_header_parser #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_byte_value,
    input  logic                              s_stream_start,
    input  logic                              s_data_ended,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic [gzhp_pkg::OUT_LEN_BITS-1:0] m_header_length,
    output logic [7:0]                        m_gzip_flags
);

    gzhp_pkg::phase_t        phase_reg, phase_next;
    logic [3:0]              pbc_reg, pbc_next;
    logic [7:0]              flag_reg, flag_next;
    logic [15:0]             xlen_reg, xlen_next;
    logic [LENGTH_BITS-1:0]  cnt_reg, cnt_next;
    logic [7:0]              zfb_reg, zfb_next;
    logic                    fmt_reg;

    logic                    emit;
    logic [2:0]              emit_status;
    logic [LENGTH_BITS-1:0]  emit_len;
    logic [7:0]              emit_flags;
    logic                    gz;
    logic                    accept;

    logic                              m_valid_reg;
    logic [2:0]                        m_status_reg;
    logic [gzhp_pkg::OUT_LEN_BITS-1:0] m_len_reg;
    logic [7:0]                        m_flags_reg;
    logic [31:0]                       emit_len_ext;

    // Next optional gzip part after the given one, done if none
    function automatic gzhp_pkg::phase_t gzip_next(input gzhp_pkg::phase_t from,
                                                   input logic [7:0] flg);
        gzhp_pkg::phase_t r;
        logic             past_x, past_n, past_c, past_h;
        past_x = (from != gzhp_pkg::PH_GFIX);
        past_n = past_x && (from != gzhp_pkg::PH_XLEN) && (from != gzhp_pkg::PH_XDATA);
        past_c = past_n && (from != gzhp_pkg::PH_NAME);
        past_h = past_c && (from != gzhp_pkg::PH_COMM);
        if (!past_x && flg[gzhp_pkg::FLG_EXTRA]) begin
            r = gzhp_pkg::PH_XLEN;
        end else if (!past_n && flg[gzhp_pkg::FLG_NAME]) begin
            r = gzhp_pkg::PH_NAME;
        end else if (!past_c && flg[gzhp_pkg::FLG_COMMENT]) begin
            r = gzhp_pkg::PH_COMM;
        end else if (!past_h && flg[gzhp_pkg::FLG_HCRC]) begin
            r = gzhp_pkg::PH_HCRC;
        end else begin
            r = gzhp_pkg::PH_DONE;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // Phase machine: next state and result for one word
    always_comb begin
        phase_next  = phase_reg;
        pbc_next    = pbc_reg;
        flag_next   = flag_reg;
        xlen_next   = xlen_reg;
        cnt_next    = cnt_reg;
        zfb_next    = zfb_reg;
        emit        = 1'b0;
        emit_status = gzhp_pkg::ST_ZLIB_OK;
        emit_len    = cnt_reg;
        emit_flags  = 8'd0;
        gz          = 1'b0;

        // restart on stream start or the first word after reset
        if (s_stream_start || (phase_reg == gzhp_pkg::PH_IDLE && !s_data_ended)) begin
            pbc_next   = '0;
            flag_next  = '0;
            xlen_next  = '0;
            cnt_next   = '0;
            zfb_next   = '0;
            phase_next = fmt_reg ? gzhp_pkg::PH_GFIX : gzhp_pkg::PH_Z0;
        end

        if (phase_next != gzhp_pkg::PH_IDLE && phase_next != gzhp_pkg::PH_DONE) begin
            gz = (phase_next != gzhp_pkg::PH_Z0) && (phase_next != gzhp_pkg::PH_Z1);
            if (s_data_ended) begin
                // header cut short
                emit        = 1'b1;
                emit_status = gz ? gzhp_pkg::ST_BAD_GZIP : gzhp_pkg::ST_BAD_ZLIB;
                emit_len    = cnt_next;
                emit_flags  = gz ? flag_next : 8'd0;
                phase_next  = gzhp_pkg::PH_DONE;
            end else begin
                // saturating byte count
                if (!(&cnt_next)) begin
                    cnt_next = cnt_next + 1'b1;
                end
                emit_len = cnt_next;
                unique case (phase_next)
                    gzhp_pkg::PH_Z0: begin
                        zfb_next   = s_byte_value;
                        phase_next = gzhp_pkg::PH_Z1;
                    end
                    gzhp_pkg::PH_Z1: begin
                        emit       = 1'b1;
                        phase_next = gzhp_pkg::PH_DONE;
                        if (zfb_next[3:0] == gzhp_pkg::ZLIB_CM_DEFL) begin
                            emit_status = s_byte_value[gzhp_pkg::ZLIB_FDICT] ?
                                          gzhp_pkg::ST_DICT : gzhp_pkg::ST_ZLIB_OK;
                        end else begin
                            emit_status = gzhp_pkg::ST_RAW;
                            emit_len    = '0;
                        end
                    end
                    gzhp_pkg::PH_GFIX: begin
                        if ((pbc_next == 4'd0 && s_byte_value != gzhp_pkg::GZIP_ID1) ||
                            (pbc_next == 4'd1 && s_byte_value != gzhp_pkg::GZIP_ID2)) begin
                            emit        = 1'b1;
                            emit_status = gzhp_pkg::ST_BAD_GZIP;
                            phase_next  = gzhp_pkg::PH_DONE;
                        end else begin
                            if (pbc_next == gzhp_pkg::GZIP_FLG_POS) begin
                                flag_next = s_byte_value;
                            end
                            pbc_next = pbc_next + 4'd1;
                            if (pbc_next >= gzhp_pkg::GZIP_FIX_LEN) begin
                                phase_next = gzip_next(gzhp_pkg::PH_GFIX, flag_next);
                                pbc_next   = '0;
                            end
                        end
                    end
                    gzhp_pkg::PH_XLEN: begin
                        if (pbc_next == 4'd0) begin
                            xlen_next = {8'd0, s_byte_value};
                            pbc_next  = 4'd1;
                        end else begin
                            xlen_next = {s_byte_value, xlen_next[7:0]};
                            pbc_next  = '0;
                            if (xlen_next == 16'd0) begin
                                phase_next = gzip_next(gzhp_pkg::PH_XDATA, flag_next);
                            end else begin
                                phase_next = gzhp_pkg::PH_XDATA;
                            end
                        end
                    end
                    gzhp_pkg::PH_XDATA: begin
                        if (xlen_next != 16'd0) begin
                            xlen_next = xlen_next - 16'd1;
                        end
                        if (xlen_next == 16'd0) begin
                            phase_next = gzip_next(gzhp_pkg::PH_XDATA, flag_next);
                            pbc_next   = '0;
                        end
                    end
                    gzhp_pkg::PH_NAME, gzhp_pkg::PH_COMM: begin
                        if (s_byte_value == 8'd0) begin
                            phase_next = gzip_next(phase_next, flag_next);
                            pbc_next   = '0;
                        end
                    end
                    gzhp_pkg::PH_HCRC: begin
                        pbc_next = pbc_next + 4'd1;
                        if (pbc_next >= 4'd2) begin
                            phase_next = gzip_next(gzhp_pkg::PH_HCRC, flag_next);
                            pbc_next   = '0;
                        end
                    end
                    default: begin
                        phase_next = gzhp_pkg::PH_DONE;
                    end
                endcase
                // gzip header complete
                if (gz && !emit && phase_next == gzhp_pkg::PH_DONE) begin
                    emit        = 1'b1;
                    emit_status = gzhp_pkg::ST_GZIP_OK;
                    emit_flags  = flag_next;
                end
            end
        end
    end

    assign emit_len_ext = 32'(emit_len);

    // State registers: advance on each accepted word; the format bit loads on a configuration handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gzhp_pkg::PH_IDLE;
            pbc_reg   <= '0;
            flag_reg  <= '0;
            xlen_reg  <= '0;
            cnt_reg   <= '0;
            zfb_reg   <= '0;
            fmt_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                fmt_reg <= cfg_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                pbc_reg   <= pbc_next;
                flag_reg  <= flag_next;
                xlen_reg  <= xlen_next;
                cnt_reg   <= cnt_next;
                zfb_reg   <= zfb_next;
            end
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_status_reg <= emit_status;
            m_len_reg    <= emit_len_ext[gzhp_pkg::OUT_LEN_BITS-1:0];
            m_flags_reg  <= emit_flags;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_header_length = m_len_reg;
    assign m_gzip_flags    = m_flags_reg;

endmodule
